>>> rtl/salru_pkg.sv
// Shared constants and types of the set-associative LRU tag store.
package salru_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WIDTH = 2'd2;

    // Outcome of one lookup.
    typedef struct packed {
        logic hit;
        logic evicted;
    } t_outcome;

endpackage

>>> rtl/salru_update.sv
// Compare, victim choice and recency update for one set read from the tag store.
module salru_update #(
    parameter int NUM_WAYS = 8
) (
    input  logic [salru_pkg::TAG_W-1:0]                    i_tag,
    input  logic [$clog2(NUM_WAYS+1)-1:0]                  i_ways,
    input  logic [NUM_WAYS-1:0][salru_pkg::TAG_W-1:0]      i_line_tag,
    input  logic [NUM_WAYS-1:0]                            i_line_valid,
    input  logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] i_rank,
    output logic [NUM_WAYS-1:0][salru_pkg::TAG_W-1:0]      o_line_tag,
    output logic [NUM_WAYS-1:0]                            o_line_valid,
    output logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] o_rank,
    output salru_pkg::t_outcome                            o_outcome,
    output logic [salru_pkg::TAG_W-1:0]                    o_victim_tag
);

    localparam int WW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RW  = WW;
    localparam int WCW = $clog2(NUM_WAYS + 1);
    localparam logic [RW-1:0] RANK_MAX = RW'(NUM_WAYS - 1);

    logic [NUM_WAYS-1:0] in_use;
    logic                hit_found;
    logic [WW-1:0]       hit_way;
    logic                free_found;
    logic [WW-1:0]       free_way;
    logic [WW-1:0]       vic_way;
    logic [RW-1:0]       vic_rank;
    logic [WW-1:0]       tgt_way;
    logic [RW-1:0]       old_rank;
    logic                age_all;

    always_comb begin
        for (int j = 0; j < NUM_WAYS; j++) begin
            in_use[j] = (WCW'(j) < i_ways);
        end
    end

    // Lowest matching way, lowest free way and oldest way of the set.
    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        vic_way    = '0;
        vic_rank   = i_rank[0];
        for (int j = 0; j < NUM_WAYS; j++) begin
            if (!hit_found && in_use[j] && i_line_valid[j] && (i_line_tag[j] == i_tag)) begin
                hit_found = 1'b1;
                hit_way   = WW'(j);
            end
            if (!free_found && in_use[j] && !i_line_valid[j]) begin
                free_found = 1'b1;
                free_way   = WW'(j);
            end
            if ((j > 0) && in_use[j] && (i_rank[j] > vic_rank)) begin
                vic_rank = i_rank[j];
                vic_way  = WW'(j);
            end
        end
    end

    always_comb begin
        o_outcome.hit     = hit_found;
        o_outcome.evicted = !hit_found && !free_found;
        if (hit_found) begin
            tgt_way  = hit_way;
            old_rank = i_rank[hit_way];
            age_all  = 1'b0;
        end else if (free_found) begin
            tgt_way  = free_way;
            old_rank = '0;
            age_all  = 1'b1;
        end else begin
            tgt_way  = vic_way;
            old_rank = vic_rank;
            age_all  = 1'b0;
        end
        o_victim_tag = o_outcome.evicted ? i_line_tag[vic_way] : '0;
    end

    // The touched way becomes most recent; younger valid ways age by one.
    always_comb begin
        for (int j = 0; j < NUM_WAYS; j++) begin
            o_line_tag[j]   = i_line_tag[j];
            o_line_valid[j] = i_line_valid[j];
            o_rank[j]       = i_rank[j];
            if (in_use[j]) begin
                if (WW'(j) == tgt_way) begin
                    o_rank[j] = '0;
                    if (!hit_found) begin
                        o_line_tag[j]   = i_tag;
                        o_line_valid[j] = 1'b1;
                    end
                end else if (i_line_valid[j] && (age_all || (i_rank[j] < old_rank))
                             && (i_rank[j] != RANK_MAX)) begin
                    o_rank[j] = i_rank[j] + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/set_assoc_lru_tag_store_top.sv
// Top level of the set-associative tag store with true LRU replacement.
//
// One address enters on the s_axis channel; one result leaves on m_axis with
// the hit and eviction flags in tuser and the victim tag and running counts in
// tdata. For each item the set is read from the single set-wide tag memory
// in the accept cycle, and compared, updated and written back in the next,
// when the result is loaded into the output register. A new item is accepted
// only once the previous one has left the lookup state, and only while the
// output register is empty or being emptied.
// After reset a clearing pass over every set invalidates every line and
// zeroes the ranks; no item is accepted during it, while configuration
// writes are taken at any time. Configuration should only be written while
// no item is in flight. When the receiver stalls, the result holds in the
// output register and the next item waits at the input.
module set_assoc_lru_tag_store_top #(
    parameter int NUM_SETS = 256,
    parameter int NUM_WAYS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [salru_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Address items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // address[31:0]
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // victim_tag[31:0], hit_total[63:32], miss_total[95:64], access_total[127:96]
    output logic [127:0]                      m_axis_tdata,
    output logic [1:0]                        m_axis_tuser    // hit[0], evicted[1]
);

    localparam int TAG_W = salru_pkg::TAG_W;
    localparam int CNT_W = salru_pkg::CNT_W;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int MAXK  = ((1 << $clog2(NUM_SETS)) == NUM_SETS) ?
                           $clog2(NUM_SETS) : ($clog2(NUM_SETS) - 1);
    localparam int RW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WCW   = $clog2(NUM_WAYS + 1);
    localparam int ENT_W = TAG_W + 1 + RW;
    localparam int ROW_W = NUM_WAYS * ENT_W;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [3:0]       r_index_width;
    logic [3:0]       r_ways_in_use;
    logic [2:0]       r_offset_width;
    logic [SET_W-1:0] r_clr_cnt;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [ROW_W-1:0] r_rdata;

    logic [ROW_W-1:0] mem [NUM_SETS];

    logic [CNT_W-1:0] r_hit_cnt, r_miss_cnt, r_acc_cnt;
    logic [CNT_W-1:0] n_hit_cnt, n_miss_cnt, n_acc_cnt;
    logic             r_out_valid;
    logic [127:0]     r_out_data;
    logic [1:0]       r_out_user;

    logic             in_acc;
    logic             out_acc;
    logic [3:0]       iw_eff;
    logic [WCW-1:0]   ways_eff;
    logic [31:0]      shifted;
    logic [31:0]      set_full;
    logic [TAG_W-1:0] acc_tag;

    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic [NUM_WAYS-1:0][TAG_W-1:0] rd_tag, wr_tag;
    logic [NUM_WAYS-1:0]            rd_valid, wr_valid;
    logic [NUM_WAYS-1:0][RW-1:0]    rd_rank, wr_rank;
    logic [ROW_W-1:0]               wr_row;
    salru_pkg::t_outcome            outcome;
    logic [TAG_W-1:0]               victim_tag;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // The output register is always free by the lookup cycle of an item.
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_width  <= 4'd0;
            r_ways_in_use  <= 4'd1;
            r_offset_width <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                salru_pkg::CFG_INDEX_WIDTH:  r_index_width  <= i_cfg_wdata;
                salru_pkg::CFG_WAYS_IN_USE:  r_ways_in_use  <= i_cfg_wdata;
                salru_pkg::CFG_OFFSET_WIDTH: r_offset_width <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        iw_eff = (r_index_width > 4'(MAXK)) ? 4'(MAXK) : r_index_width;
        if (r_ways_in_use == 4'd0) begin
            ways_eff = WCW'(1);
        end else if (32'(r_ways_in_use) > 32'(NUM_WAYS)) begin
            ways_eff = WCW'(NUM_WAYS);
        end else begin
            ways_eff = WCW'(r_ways_in_use);
        end
        shifted  = s_axis_tdata >> r_offset_width;
        set_full = shifted & ((32'h1 << iw_eff) - 32'h1);
        acc_tag  = shifted >> iw_eff;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_cnt == SET_W'(NUM_SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (in_acc) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set <= set_full[SET_W-1:0];
            r_tag <= acc_tag;
        end
    end

    // Set-wide tag memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= mem[set_full[SET_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_comb begin
        mem_we    = (r_state == ST_CLEAR) || (r_state == ST_LOOKUP);
        mem_waddr = (r_state == ST_CLEAR) ? r_clr_cnt : r_set;
        mem_wdata = (r_state == ST_CLEAR) ? '0 : wr_row;
    end

    // Each way holds {rank, valid, tag}, way 0 lowest.
    always_comb begin
        for (int j = 0; j < NUM_WAYS; j++) begin
            rd_tag[j]   = r_rdata[j*ENT_W +: TAG_W];
            rd_valid[j] = r_rdata[j*ENT_W + TAG_W];
            rd_rank[j]  = r_rdata[j*ENT_W + TAG_W + 1 +: RW];
            wr_row[j*ENT_W +: ENT_W] = {wr_rank[j], wr_valid[j], wr_tag[j]};
        end
    end

    salru_update #(
        .NUM_WAYS (NUM_WAYS)
    ) u_update (
        .i_tag        (r_tag),
        .i_ways       (ways_eff),
        .i_line_tag   (rd_tag),
        .i_line_valid (rd_valid),
        .i_rank       (rd_rank),
        .o_line_tag   (wr_tag),
        .o_line_valid (wr_valid),
        .o_rank       (wr_rank),
        .o_outcome    (outcome),
        .o_victim_tag (victim_tag)
    );

    assign n_hit_cnt  = r_hit_cnt + CNT_W'(outcome.hit);
    assign n_miss_cnt = r_miss_cnt + CNT_W'(!outcome.hit);
    assign n_acc_cnt  = r_acc_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else if (r_state == ST_LOOKUP) begin
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_acc_cnt   <= n_acc_cnt;
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOKUP) begin
            r_out_data <= {n_acc_cnt, n_miss_cnt, n_hit_cnt, victim_tag};
            r_out_user <= {outcome.evicted, outcome.hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Every accepted item has its result presented once its lookup state is over.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 m_axis_tvalid)
        else $error("result not presented two cycles after its item");

    // The access count is always the sum of hits and misses.
    a_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[127:96] == m_axis_tdata[95:64] + m_axis_tdata[63:32]))
        else $error("access count differs from hits plus misses");

    // A hit never evicts, and no victim tag is reported without an eviction.
    a_victim_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])
                          && (m_axis_tuser[1] || (m_axis_tdata[31:0] == '0)))
        else $error("inconsistent hit, eviction and victim tag");

    // The memory is never written in the cycle that an item is read.
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !mem_we)
        else $error("memory written in an accept cycle");

    // The clearing pass runs to completion before the first item.
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) && (r_clr_cnt != SET_W'(NUM_SETS - 1)) |=> (r_state == ST_CLEAR))
        else $error("clearing pass left early");

endmodule
